// ----- sv/hac_pkg.sv -----
// Shared types, constants and angle tables for the heading align controller.
`default_nettype none

package hac_pkg;

  // Width of the CORDIC x/y datapath: 17-bit differences scaled by 2^16 plus gain growth.
  localparam int XW = 36;

  // Configuration port.
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 16;

  localparam logic [CFG_IW-1:0] REG_TARGET_X       = 3'd0;
  localparam logic [CFG_IW-1:0] REG_TARGET_Y       = 3'd1;
  localparam logic [CFG_IW-1:0] REG_STOP_THRESHOLD = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SLOW_THRESHOLD = 3'd3;
  localparam logic [CFG_IW-1:0] REG_MAX_SPIN       = 3'd4;
  localparam logic [CFG_IW-1:0] REG_RESPONSE_GAIN  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_MAX_ACCEL      = 3'd6;

  localparam logic [14:0] STOP_RST  = 15'd410;
  localparam logic [14:0] SLOW_RST  = 15'd819;
  localparam logic [14:0] SPIN_RST  = 15'd819;
  localparam logic [9:0]  GAIN_RST  = 10'd100;
  localparam logic [14:0] ACCEL_RST = 15'd819;

  // Quotient bits of the scaled-spin divider.
  localparam int DIV_QB = 15;

  localparam longint unsigned PI_Q30 = 64'd3373259426;

  // Truncated Q.30 arctangents of 2^-i.
  function automatic longint unsigned atan_q30(input int idx);
    longint unsigned v;
    case (idx)
      0:       v = 64'd843314856;
      1:       v = 64'd497837829;
      2:       v = 64'd263043836;
      3:       v = 64'd133525158;
      4:       v = 64'd67021686;
      5:       v = 64'd33543515;
      6:       v = 64'd16775850;
      7:       v = 64'd8388437;
      8:       v = 64'd4194282;
      9:       v = 64'd2097149;
      10:      v = 64'd1048575;
      11:      v = 64'd524287;
      12:      v = 64'd262143;
      13:      v = 64'd131071;
      14:      v = 64'd65535;
      15:      v = 64'd32767;
      16:      v = 64'd16383;
      17:      v = 64'd8191;
      18:      v = 64'd4095;
      19:      v = 64'd2047;
      20:      v = 64'd1023;
      21:      v = 64'd511;
      22:      v = 64'd255;
      23:      v = 64'd127;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  // Round a Q.30 value to the angle format with frac fraction bits.
  function automatic longint unsigned to_angle(input longint unsigned q30, input int frac);
    int sh;
    sh = 30 - frac;
    return (q30 + (64'd1 << (sh - 1))) >> sh;
  endfunction

  typedef struct packed {
    logic signed [15:0] heading;
    logic signed [15:0] spin;
    logic               at_target;
  } hac_side_t;

  typedef struct packed {
    logic signed [15:0] spin;
    logic               at_target;
  } hac_spin_t;

  typedef struct packed {
    logic signed [15:0] spin;
    logic               at_target;
    logic               neg;
    logic               aligned;
    logic               scaled;
  } hac_ctl_t;

endpackage

`default_nettype wire

// ----- sv/heading_align_controller.sv -----
// Top level of the heading align controller: config registers and the steering pipeline.
//
// Input channel (in_*): one item per body sample - position, heading and spin.
// Result channel (out_*): one item per input item, in order - the commanded
// angular acceleration and the turning flag. Both use valid/stall; an item
// moves on an edge where valid is high and stall is low.
// Config port (cfg_*): write cfg_data to register cfg_index when cfg_we is
// high. Write only while no item is in flight.
// Pipeline: input register, pre-rotation, CORDIC_STAGES CORDIC stages, five
// wrap stages (error, offset, reciprocal multiply, times 2*pi, remainder),
// two magnitude/threshold stages, fifteen divider stages (one quotient bit
// each), spin error, gain multiply and the output register.
// Throughput: one item per cycle while no result is held under out_stall.
// Stall: while a result waits under out_stall the whole pipeline holds and
// in_stall is raised; nothing in flight is lost or repeated.
// Reset (synchronous, rst_n low): empties the pipeline and returns the
// config registers to their defaults; no clearing pass is needed.
`default_nettype none

module heading_align_controller
  import hac_pkg::*;
#(
  parameter int CORDIC_STAGES   = 16,
  parameter int ANGLE_FRAC_BITS = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [15:0]  in_pos_x,
  input  logic signed [15:0]  in_pos_y,
  input  logic signed [15:0]  in_heading,
  input  logic signed [15:0]  in_spin,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_angular_accel,
  output logic                out_turning,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_data
);

  // Angle width: sign, enough integer bits for pi plus CORDIC overshoot.
  localparam int ZW = ANGLE_FRAC_BITS + 4;
  localparam int MW = ((ZW - 1) > 15) ? (ZW - 1) : 15;

  // ---------------------------------------------------------------- config
  logic signed [15:0] target_x_r, target_y_r;
  logic [14:0]        stop_r, slow_r, max_spin_r, max_accel_r;
  logic [9:0]         gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_x_r  <= '0;
      target_y_r  <= '0;
      stop_r      <= STOP_RST;
      slow_r      <= SLOW_RST;
      max_spin_r  <= SPIN_RST;
      gain_r      <= GAIN_RST;
      max_accel_r <= ACCEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET_X:       target_x_r  <= cfg_data;
        REG_TARGET_Y:       target_y_r  <= cfg_data;
        REG_STOP_THRESHOLD: stop_r      <= cfg_data[14:0];
        REG_SLOW_THRESHOLD: slow_r      <= cfg_data[14:0];
        REG_MAX_SPIN:       max_spin_r  <= cfg_data[14:0];
        REG_RESPONSE_GAIN:  gain_r      <= cfg_data[9:0];
        REG_MAX_ACCEL:      max_accel_r <= cfg_data[14:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ------------------------------------------------------- flow control
  // One enable for every stage: advance unless a finished result is stalled.
  logic out_valid_r;
  logic adv;

  assign in_stall = out_valid_r && out_stall;
  assign adv      = !in_stall;

  // ------------------------------------------------------ input register
  logic signed [16:0] dx_nxt, dy_nxt, dx_r, dy_r;
  logic               vi_r;
  hac_side_t          side_nxt, side_r;

  always_comb begin
    dx_nxt             = {target_x_r[15], target_x_r} - {in_pos_x[15], in_pos_x};
    dy_nxt             = {target_y_r[15], target_y_r} - {in_pos_y[15], in_pos_y};
    side_nxt.heading   = in_heading;
    side_nxt.spin      = in_spin;
    side_nxt.at_target = (dx_nxt == '0) && (dy_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vi_r <= 1'b0;
    end else if (adv) begin
      vi_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      side_r <= side_nxt;
    end
  end

  // ------------------------------------------------------------ CORDIC
  logic                 vc;
  logic signed [ZW-1:0] zc;
  logic [$bits(hac_side_t)-1:0] sc_bits;
  hac_side_t            sc;

  hac_cordic #(
    .STAGES (CORDIC_STAGES),
    .FRAC   (ANGLE_FRAC_BITS),
    .ZW     (ZW),
    .SW     ($bits(hac_side_t))
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (vi_r),
    .in_dx     (dx_r),
    .in_dy     (dy_r),
    .in_side   (side_r),
    .out_valid (vc),
    .out_z     (zc),
    .out_side  (sc_bits)
  );

  assign sc = hac_side_t'(sc_bits);

  // -------------------------------------------------------------- wrap
  hac_spin_t            sw_in, sw;
  logic [$bits(hac_spin_t)-1:0] sw_bits;
  logic                 vw;
  logic signed [ZW-1:0] err;

  assign sw_in.spin      = sc.spin;
  assign sw_in.at_target = sc.at_target;

  hac_wrap #(
    .FRAC (ANGLE_FRAC_BITS),
    .ZW   (ZW),
    .SW   ($bits(hac_spin_t))
  ) u_wrap (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (vc),
    .in_z       (zc),
    .in_heading (sc.heading),
    .in_side    (sw_in),
    .out_valid  (vw),
    .out_err    (err),
    .out_side   (sw_bits)
  );

  assign sw = hac_spin_t'(sw_bits);

  // ---------------------------------------------------- magnitude (M1)
  logic signed [ZW-1:0] err_abs;
  logic [ZW-2:0]        mag_r;
  logic                 neg_r, vm1_r;
  hac_spin_t            sm1_r;

  assign err_abs = err[ZW-1] ? -err : err;

  // ------------------------------------------- thresholds, dividend (M2)
  logic [MW-1:0] mag_ext;
  logic [29:0]   dividend_nxt, dividend_r;
  hac_ctl_t      ctl_nxt, ctl_r;
  logic          vm2_r;

  always_comb begin
    mag_ext           = MW'(mag_r);
    ctl_nxt.spin      = sm1_r.spin;
    ctl_nxt.at_target = sm1_r.at_target;
    ctl_nxt.neg       = neg_r;
    ctl_nxt.aligned   = mag_ext < MW'(stop_r);
    // Scale only inside the slow zone; a zero slow threshold means full spin.
    ctl_nxt.scaled    = (slow_r != '0) && (mag_ext <= MW'(slow_r));
    dividend_nxt      = max_spin_r * mag_ext[14:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm1_r <= 1'b0;
      vm2_r <= 1'b0;
    end else if (adv) begin
      vm1_r <= vw;
      vm2_r <= vm1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r      <= err_abs[ZW-2:0];
      neg_r      <= err[ZW-1];
      sm1_r      <= sw;
      dividend_r <= dividend_nxt;
      ctl_r      <= ctl_nxt;
    end
  end

  // ----------------------------------------------------------- divider
  logic                        vd;
  logic [DIV_QB-1:0]           quo;
  logic [$bits(hac_ctl_t)-1:0] sd_bits;
  hac_ctl_t                    sd;

  hac_div #(
    .QB (DIV_QB),
    .SW ($bits(hac_ctl_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (vm2_r),
    .in_num    (dividend_r),
    .in_den    (slow_r),
    .in_side   (ctl_r),
    .out_valid (vd),
    .out_quo   (quo),
    .out_side  (sd_bits)
  );

  assign sd = hac_ctl_t'(sd_bits);

  // -------------------------------------------------- spin error (F1)
  logic [14:0]        dmag;
  logic signed [15:0] dmag_s, desired;
  logic signed [16:0] diff_nxt, diff_r;
  hac_ctl_t           cf1_r, cf2_r;
  logic               vf1_r, vf2_r;

  always_comb begin
    dmag     = sd.scaled ? quo : max_spin_r;
    dmag_s   = {1'b0, dmag};
    // Zero error counts as positive.
    desired  = sd.neg ? -dmag_s : dmag_s;
    diff_nxt = {desired[15], desired} - {sd.spin[15], sd.spin};
  end

  // ------------------------------------------------------ gain (F2)
  logic signed [10:0] gain_s;
  logic signed [27:0] prod_nxt, prod_r;

  assign gain_s   = {1'b0, gain_r};
  assign prod_nxt = 28'(diff_r) * 28'(gain_s);

  // --------------------------------------------- clamp, output register
  logic signed [27:0] lim;
  logic signed [15:0] accel_nxt;
  logic               turning_nxt;
  logic signed [15:0] out_accel_r;
  logic               out_turning_r;

  always_comb begin
    lim         = {13'd0, max_accel_r};
    turning_nxt = !(cf2_r.at_target || cf2_r.aligned);
    priority if (!turning_nxt) begin
      accel_nxt = '0;
    end else if (prod_r > lim) begin
      accel_nxt = lim[15:0];
    end else if (prod_r < -lim) begin
      accel_nxt = -lim[15:0];
    end else begin
      accel_nxt = prod_r[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf1_r       <= 1'b0;
      vf2_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vf1_r       <= vd;
      vf2_r       <= vf1_r;
      out_valid_r <= vf2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r        <= diff_nxt;
      cf1_r         <= sd;
      prod_r        <= prod_nxt;
      cf2_r         <= cf1_r;
      out_accel_r   <= accel_nxt;
      out_turning_r <= turning_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_angular_accel = out_accel_r;
  assign out_turning       = out_turning_r;

`ifndef NO_ASSERTIONS
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled without a waiting result");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_turning_r) |-> (out_accel_r == '0))
    else $error("nonzero acceleration without a turn");

  a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_turning_r) |->
      ((17'(out_accel_r) <= $signed({2'b00, max_accel_r})) &&
       (17'(out_accel_r) >= -$signed({2'b00, max_accel_r}))))
    else $error("acceleration beyond the limit");
`endif

endmodule

`default_nettype wire

// ----- sv/hac_cordic.sv -----
// Pipelined vectoring CORDIC: angle of (dx, dy), one stage per iteration.
`default_nettype none

module hac_cordic
  import hac_pkg::*;
#(
  parameter int STAGES = 16,
  parameter int FRAC   = 13,
  parameter int ZW     = 17,
  parameter int SW     = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [16:0]   in_dx,
  input  logic signed [16:0]   in_dy,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [ZW-1:0] out_z,
  output logic [SW-1:0]        out_side
);

  localparam logic signed [ZW-1:0] PI_Z = ZW'(to_angle(PI_Q30, FRAC));

  logic signed [XW-1:0] xs [STAGES+1];
  logic signed [XW-1:0] ys [STAGES+1];
  logic signed [ZW-1:0] zs [STAGES+1];
  logic                 vs [STAGES+1];
  logic [SW-1:0]        ss [STAGES+1];

  // Pre-rotation: fold the left half-plane onto the right one.
  logic signed [XW-1:0] xe, ye;
  logic signed [XW-1:0] x0_nxt, y0_nxt, x0_r, y0_r;
  logic signed [ZW-1:0] z0_nxt, z0_r;
  logic                 v0_r;
  logic [SW-1:0]        s0_r;

  always_comb begin
    xe = {{(XW-33){in_dx[16]}}, in_dx, 16'd0};
    ye = {{(XW-33){in_dy[16]}}, in_dy, 16'd0};
    if (in_dx[16]) begin
      x0_nxt = -xe;
      y0_nxt = -ye;
      z0_nxt = in_dy[16] ? -PI_Z : PI_Z;
    end else begin
      x0_nxt = xe;
      y0_nxt = ye;
      z0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r <= x0_nxt;
      y0_r <= y0_nxt;
      z0_r <= z0_nxt;
      s0_r <= in_side;
    end
  end

  assign xs[0] = x0_r;
  assign ys[0] = y0_r;
  assign zs[0] = z0_r;
  assign vs[0] = v0_r;
  assign ss[0] = s0_r;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ANG = ZW'(to_angle(atan_q30(i), FRAC));

    logic signed [XW-1:0] x_nxt, y_nxt, x_r, y_r;
    logic signed [ZW-1:0] z_nxt, z_r;
    logic                 v_r;
    logic [SW-1:0]        s_r;

    // Rotate toward y = 0.
    always_comb begin
      if (!ys[i][XW-1]) begin
        x_nxt = xs[i] + (ys[i] >>> i);
        y_nxt = ys[i] - (xs[i] >>> i);
        z_nxt = zs[i] + ANG;
      end else begin
        x_nxt = xs[i] - (ys[i] >>> i);
        y_nxt = ys[i] + (xs[i] >>> i);
        z_nxt = zs[i] - ANG;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= vs[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        s_r <= ss[i];
      end
    end

    assign xs[i+1] = x_r;
    assign ys[i+1] = y_r;
    assign zs[i+1] = z_r;
    assign vs[i+1] = v_r;
    assign ss[i+1] = s_r;
  end

  assign out_valid = vs[STAGES];
  assign out_z     = zs[STAGES];
  assign out_side  = ss[STAGES];

endmodule

`default_nettype wire

// ----- sv/hac_wrap.sv -----
// Heading error and its wrap into [-pi, pi] by reciprocal multiplication.
`default_nettype none

module hac_wrap
  import hac_pkg::*;
#(
  parameter int FRAC = 13,
  parameter int ZW   = 17,
  parameter int SW   = 17
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_valid,
  input  logic signed [ZW-1:0] in_z,
  input  logic signed [15:0]   in_heading,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic signed [ZW-1:0] out_err,
  output logic [SW-1:0]        out_side
);

  localparam int     EW    = ((ZW > 16) ? ZW : 16) + 2;
  localparam int     WW    = EW + 1;
  localparam longint PI_L  = longint'(to_angle(PI_Q30, FRAC));
  localparam longint TP_L  = 2 * PI_L;
  localparam longint MUL_L = ((64'sd1 <<< EW) + TP_L - 1) / TP_L;
  localparam longint OFF_L = MUL_L * TP_L;
  localparam longint RCP_L = (64'sd1 <<< WW) / TP_L;
  localparam int     RW    = $clog2(RCP_L + 1);

  localparam logic signed [EW-1:0] PI_E  = EW'(PI_L);
  localparam logic signed [ZW-1:0] PI_Z  = ZW'(PI_L);
  localparam logic [WW-1:0]        TP_W  = WW'(TP_L);
  localparam logic [WW-1:0]        OFF_W = WW'(OFF_L);
  localparam logic [RW-1:0]        RCP_R = RW'(RCP_L);

  // Stage E: raw error.
  logic signed [EW-1:0] err_nxt, err_r;
  logic                 ve_r;
  logic [SW-1:0]        se_r;

  assign err_nxt = {{(EW-ZW){in_z[ZW-1]}}, in_z} - {{(EW-16){in_heading[15]}}, in_heading};

  // Stage W1: shift into a positive range, pick the window base.
  logic                 hi, lo;
  logic signed [ZW-1:0] base_nxt;
  logic [WW-1:0]        w_nxt;
  logic [WW-1:0]        w1_r, w2_r, w3_r;
  logic signed [ZW-1:0] b1_r, b2_r, b3_r;
  logic signed [ZW-1:0] e1_r, e2_r, e3_r;
  logic                 in1_r, in2_r, in3_r;
  logic                 v1_r, v2_r, v3_r, v4_r;
  logic [SW-1:0]        s1_r, s2_r, s3_r, s4_r;

  always_comb begin
    hi       = err_r > PI_E;
    lo       = err_r < -PI_E;
    base_nxt = hi ? (ZW'(1) - PI_Z) : -PI_Z;
    w_nxt    = WW'(err_r) - WW'(base_nxt) + OFF_W;
  end

  // Stage W2: quotient estimate, low by at most one.
  logic [WW+RW-1:0] prod;
  logic [RW-1:0]    q_nxt, q_r;

  assign prod  = w1_r * RCP_R;
  assign q_nxt = prod[WW +: RW];

  // Stage W3: quotient times 2*pi.
  logic [WW+RW-1:0] qt_full;
  logic [WW-1:0]    qt_r;

  assign qt_full = q_r * TP_W;

  // Stage W4: remainder, one correction, rebase.
  logic [WW-1:0]        rem0, rem1;
  logic signed [ZW-1:0] r_nxt, r_r;

  always_comb begin
    rem0 = w3_r - qt_r;
    rem1 = (rem0 >= TP_W) ? (rem0 - TP_W) : rem0;
    if (in3_r) begin
      r_nxt = e3_r;
    end else begin
      r_nxt = $signed({1'b0, rem1[ZW-2:0]}) + b3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      ve_r <= in_valid;
      v1_r <= ve_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      err_r <= err_nxt;
      se_r  <= in_side;
      w1_r  <= w_nxt;
      b1_r  <= base_nxt;
      e1_r  <= err_r[ZW-1:0];
      in1_r <= !(hi || lo);
      s1_r  <= se_r;
      q_r   <= q_nxt;
      w2_r  <= w1_r;
      b2_r  <= b1_r;
      e2_r  <= e1_r;
      in2_r <= in1_r;
      s2_r  <= s1_r;
      qt_r  <= qt_full[WW-1:0];
      w3_r  <= w2_r;
      b3_r  <= b2_r;
      e3_r  <= e2_r;
      in3_r <= in2_r;
      s3_r  <= s2_r;
      r_r   <= r_nxt;
      s4_r  <= s3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_err   = r_r;
  assign out_side  = s4_r;

`ifndef NO_ASSERTIONS
  a_err_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (r_r <= PI_Z) && (r_r >= -PI_Z))
    else $error("wrapped heading error outside [-pi, pi]");
`endif

endmodule

`default_nettype wire

// ----- sv/hac_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module hac_div #(
  parameter int QB = 15,
  parameter int SW = 20
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [2*QB-1:0] in_num,
  input  logic [QB-1:0]   in_den,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [QB-1:0]   out_quo,
  output logic [SW-1:0]   out_side
);

  logic [QB-1:0] rems [QB+1];
  logic [QB-1:0] lows [QB+1];
  logic [QB-1:0] quos [QB+1];
  logic          vs   [QB+1];
  logic [SW-1:0] ss   [QB+1];

  assign rems[0] = in_num[2*QB-1:QB];
  assign lows[0] = in_num[QB-1:0];
  assign quos[0] = '0;
  assign vs[0]   = in_valid;
  assign ss[0]   = in_side;

  for (genvar k = 0; k < QB; k++) begin : g_bit
    logic [QB:0]   t, d;
    logic          ge;
    logic [QB-1:0] rem_r, low_r, quo_r;
    logic          v_r;
    logic [SW-1:0] s_r;

    // Bring down the next dividend bit, subtract when it fits.
    always_comb begin
      t  = {rems[k], lows[k][QB-1]};
      ge = t >= {1'b0, in_den};
      d  = t - {1'b0, in_den};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (adv) begin
        v_r <= vs[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r <= ge ? d[QB-1:0] : t[QB-1:0];
        low_r <= {lows[k][QB-2:0], 1'b0};
        quo_r <= {quos[k][QB-2:0], ge};
        s_r   <= ss[k];
      end
    end

    assign rems[k+1] = rem_r;
    assign lows[k+1] = low_r;
    assign quos[k+1] = quo_r;
    assign vs[k+1]   = v_r;
    assign ss[k+1]   = s_r;
  end

  assign out_valid = vs[QB];
  assign out_quo   = quos[QB];
  assign out_side  = ss[QB];

endmodule

`default_nettype wire
